>>> hw/rtl/aob_pkg.sv
// Shared types and constants for the angular occlusion bitmap.
package aob_pkg;

    localparam int RES_BITS   = 12;
    localparam int ANGLE_W    = 32;
    localparam int WORD_W     = 32;
    localparam int OFF_BITS   = 5;
    localparam int WADDR_BITS = RES_BITS - OFF_BITS;
    localparam int MAP_WORDS  = 1 << WADDR_BITS;
    localparam int STEP_BITS  = WADDR_BITS + 1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_BLOCK = 2'd1,
        CMD_TEST  = 2'd2
    } t_command;

    typedef struct packed {
        logic load;
        logic clear;
        logic issue;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic last_issue;
        logic is_test;
        logic out_free;
    } t_dp_status;

endpackage

>>> hw/rtl/aob_ram.sv
// Generic simple dual-port RAM with registered read.
module aob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/aob_ctrl.sv
// Controller state machine for the angular occlusion bitmap.
module aob_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_command,
    output logic                o_in_ready,
    input  aob_pkg::t_dp_status i_status,
    output aob_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == aob_pkg::CMD_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else if (i_command == aob_pkg::CMD_BLOCK ||
                                 i_command == aob_pkg::CMD_TEST) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last word is processed in this cycle
                n_state = i_status.is_test ? S_PUSH : S_IDLE;
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/aob_dp.sv
// Datapath: map RAM, word walk, masking and result register.
module aob_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [1:0]                     i_command,
    input  logic [aob_pkg::ANGLE_W-1:0]    i_low_angle,
    input  logic [aob_pkg::ANGLE_W-1:0]    i_high_angle,
    input  aob_pkg::t_dp_cmd               i_cmd,
    output aob_pkg::t_dp_status            o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_fully_blocked
);

    localparam int RB = aob_pkg::RES_BITS;
    localparam int OB = aob_pkg::OFF_BITS;
    localparam int WB = aob_pkg::WADDR_BITS;
    localparam int SB = aob_pkg::STEP_BITS;
    localparam int WW = aob_pkg::WORD_W;

    logic [RB-1:0] w_lo, w_hi;
    logic [WB-1:0] w_lo_w, w_hi_w;
    logic          w_wrap_same;

    logic [RB-1:0] r_lo, r_hi;
    logic          r_is_test;
    logic [SB-1:0] r_step, r_count_m1;
    logic [aob_pkg::MAP_WORDS-1:0] r_wvalid;

    logic          r_s1_valid, r_s1_first, r_s1_last, r_s1_vbit;
    logic [WB-1:0] r_s1_addr;
    logic          r_flag;
    logic          r_out_valid, r_out_flag;

    logic [WB-1:0] w_raddr;
    logic [WW-1:0] w_q, w_word, w_from, w_to, w_mask, w_wdata;
    logic          w_we;

    assign w_lo   = i_low_angle[aob_pkg::ANGLE_W-1 -: RB];
    assign w_hi   = i_high_angle[aob_pkg::ANGLE_W-1 -: RB];
    assign w_lo_w = w_lo[RB-1:OB];
    assign w_hi_w = w_hi[RB-1:OB];
    // wrap that starts and ends in the same word visits it twice
    assign w_wrap_same = (w_lo > w_hi) && (w_lo_w == w_hi_w);

    assign w_raddr = r_lo[RB-1:OB] + r_step[WB-1:0];

    assign o_status.last_issue = (r_step == r_count_m1);
    assign o_status.is_test    = r_is_test;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign w_word = r_s1_vbit ? w_q : '1;
    assign w_from = r_s1_first ? ({WW{1'b1}} >> r_lo[OB-1:0]) : '1;
    assign w_to   = r_s1_last ? ({WW{1'b1}} << (OB'(WW - 1) - r_hi[OB-1:0])) : '1;
    assign w_mask = w_from & w_to;
    assign w_wdata = w_word & ~w_mask;
    assign w_we    = r_s1_valid && !r_is_test;

    aob_ram #(
        .WIDTH(WW),
        .DEPTH(aob_pkg::MAP_WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_s1_addr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo       <= w_lo;
            r_hi       <= w_hi;
            r_is_test  <= (i_command == aob_pkg::CMD_TEST);
            r_count_m1 <= {w_wrap_same, WB'(w_hi_w - w_lo_w)};
        end
        r_s1_addr  <= w_raddr;
        r_s1_first <= (r_step == '0);
        r_s1_last  <= (r_step == r_count_m1);
        r_s1_vbit  <= r_wvalid[w_raddr];
        if (i_cmd.push) begin
            r_out_flag <= r_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_s1_valid  <= 1'b0;
            r_flag      <= 1'b1;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            if (i_cmd.load) begin
                r_step <= '0;
                r_flag <= 1'b1;
            end else if (i_cmd.issue) begin
                r_step <= r_step + SB'(1);
            end
            if (r_s1_valid && r_is_test && ((w_word & w_mask) != '0)) begin
                r_flag <= 1'b0;
            end
            // unwritten words read as all open
            if (i_cmd.clear) begin
                r_wvalid <= '0;
            end else if (w_we) begin
                r_wvalid[r_s1_addr] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fully_blocked = r_out_flag;

endmodule

>>> hw/rtl/angular_occlusion_bitmap.sv
// Top level of the angular occlusion bitmap: controller plus datapath.
// Clear is done on acceptance. Block and test visit one map word per cycle
// through the RAM's registered read, 1 to 129 words per command; test then
// loads the result register when the output is free, freeing the input side.
// Reset (synchronous, active low) and clear mark every word open at once.
module angular_occlusion_bitmap (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_command,
    input  logic [aob_pkg::ANGLE_W-1:0] i_low_angle,
    input  logic [aob_pkg::ANGLE_W-1:0] i_high_angle,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_fully_blocked
);

    aob_pkg::t_dp_cmd    w_cmd;
    aob_pkg::t_dp_status w_status;

    aob_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_command (i_command),
        .o_in_ready(o_in_ready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    aob_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_command),
        .i_low_angle    (i_low_angle),
        .i_high_angle   (i_high_angle),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_fully_blocked(o_fully_blocked)
    );

endmodule
